// ===== rtl/ndrm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ndrm_pkg;

	localparam int unsigned MAX_RING_DEPTH = 4096;
	localparam int unsigned BUFFER_BYTES   = 2048;

	localparam int unsigned IDX_W  = 12;
	localparam int unsigned LEN_W  = 16;
	localparam int unsigned RLEN_W = 13;
	localparam int unsigned ADDR_W = 64;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned CFG_W  = 64;

	// Largest ring the index width and the depth limit allow
	localparam int unsigned RING_CAP =
		(MAX_RING_DEPTH < (1 << IDX_W)) ? MAX_RING_DEPTH : (1 << IDX_W);

	localparam logic [WORD_W-1:0] TXD_CMD_EOP  = 32'h0100_0000;
	localparam logic [WORD_W-1:0] TXD_CMD_IFCS = 32'h0200_0000;

	localparam logic [IDX_W-1:0] RESET_MASK = 12'h0ff;

	typedef enum logic {
		CMD_TX = 1'b0,
		CMD_RX = 1'b1
	} ndrm_cmd_t;

	typedef enum logic [1:0] {
		CFG_TX_RING_LEN = 2'd0,
		CFG_RX_RING_LEN = 2'd1,
		CFG_TX_BUF_BASE = 2'd2,
		CFG_RX_BUF_BASE = 2'd3
	} ndrm_cfg_idx_t;

	typedef enum logic [2:0] {
		ST_TX_QUEUED    = 3'd0,
		ST_TX_OVERSIZE  = 3'd1,
		ST_TX_FULL      = 3'd2,
		ST_RX_DELIVERED = 3'd3,
		ST_RX_EMPTY     = 3'd4
	} ndrm_status_t;

	typedef struct packed {
		logic             cmd;
		logic [LEN_W-1:0] pkt_len;
		logic [IDX_W-1:0] hw_head;
		logic             end_of_batch;
	} ndrm_req_t;

	typedef struct packed {
		ndrm_status_t      status;
		logic [IDX_W-1:0]  desc_index;
		logic [ADDR_W-1:0] desc_addr;
		logic [WORD_W-1:0] desc_word;
		logic [ADDR_W-1:0] rx_buf_addr;
		logic              doorbell_valid;
		logic [IDX_W-1:0]  doorbell_value;
	} ndrm_rsp_t;

	// Clamp a ring length and turn it into an index mask (power of two minus one)
	function automatic logic [IDX_W-1:0] ring_mask(input logic [RLEN_W-1:0] len);
		logic [RLEN_W-1:0] v;
		logic [IDX_W-1:0]  m;
		v = len;
		if (v > RLEN_W'(RING_CAP)) v = RLEN_W'(RING_CAP);
		if (v < RLEN_W'(2)) v = RLEN_W'(2);
		m = v[RLEN_W-1:1];
		m = m | (m >> 1);
		m = m | (m >> 2);
		m = m | (m >> 4);
		m = m | (m >> 8);
		return m;
	endfunction

	// Buffer address of a ring slot; buffers are a power of two in size
	function automatic logic [ADDR_W-1:0] slot_addr(input logic [ADDR_W-1:0] base,
		input logic [IDX_W-1:0] idx);
		return base + (ADDR_W'(idx) << $clog2(BUFFER_BYTES));
	endfunction

endpackage

`default_nettype wire

// ===== rtl/ndrm_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface ndrm_req_if;
	import ndrm_pkg::*;

	logic             valid;
	logic             ready;
	logic             cmd;
	logic [LEN_W-1:0] pkt_len;
	logic [IDX_W-1:0] hw_head;
	logic             end_of_batch;

	modport source (output valid, output cmd, output pkt_len, output hw_head,
		output end_of_batch, input ready);
	modport sink (input valid, input cmd, input pkt_len, input hw_head,
		input end_of_batch, output ready);
endinterface

`default_nettype wire

// ===== rtl/ndrm_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface ndrm_rsp_if;
	import ndrm_pkg::*;

	logic              valid;
	logic              ready;
	logic [2:0]        status;
	logic [IDX_W-1:0]  desc_index;
	logic [ADDR_W-1:0] desc_addr;
	logic [WORD_W-1:0] desc_word;
	logic [ADDR_W-1:0] rx_buf_addr;
	logic              doorbell_valid;
	logic [IDX_W-1:0]  doorbell_value;

	modport source (output valid, output status, output desc_index, output desc_addr,
		output desc_word, output rx_buf_addr, output doorbell_valid,
		output doorbell_value, input ready);
	modport sink (input valid, input status, input desc_index, input desc_addr,
		input desc_word, input rx_buf_addr, input doorbell_valid,
		input doorbell_value, output ready);
endinterface

`default_nettype wire

// ===== rtl/nic_descriptor_ring_manager_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Word
// req       sink       cmd, pkt_len, hw_head, end_of_batch
// rsp       source     status, desc_index, desc_addr, desc_word, rx_buf_addr, doorbell
// cfg_*     write      cfg_index selects ring length or buffer base, cfg_wdata
//
// One word in, one word out, one word per cycle sustained while rsp is ready.
// The req word is registered, resolved against the ring pointers in one pass of
// mask, compare and slot address arithmetic, and held in the result register.
// Reset clears the pointers and batch flags and sets both rings to 256 slots.
// A stalled rsp holds the result register; req stays ready while the input register is empty or advances.

module nic_descriptor_ring_manager_core
	import ndrm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_wdata,
	ndrm_req_if.sink               req,
	ndrm_rsp_if.source             rsp
);

	logic [IDX_W-1:0]  tx_mask_q;
	logic [IDX_W-1:0]  rx_mask_q;
	logic [ADDR_W-1:0] tx_base_q;
	logic [ADDR_W-1:0] rx_base_q;

	logic [IDX_W-1:0]  tx_tail_q;
	logic [IDX_W-1:0]  rx_next_q;
	logic              tx_moved_q;
	logic              rx_moved_q;

	logic              valid_s1;
	ndrm_req_t         req_s1;
	logic              valid_s2;
	ndrm_rsp_t         rsp_s2;

	logic              advance;
	ndrm_rsp_t         rsp_d;
	logic [IDX_W-1:0]  tx_tail_d;
	logic [IDX_W-1:0]  rx_next_d;
	logic              tx_moved_d;
	logic              rx_moved_d;

	logic [IDX_W-1:0]  head;
	logic [IDX_W-1:0]  tail;
	logic [IDX_W-1:0]  room;
	logic [IDX_W-1:0]  cur;
	logic [IDX_W-1:0]  avail;
	logic [IDX_W-1:0]  refill;
	logic [IDX_W-1:0]  slot;
	logic [ADDR_W-1:0] slot_base;
	logic [ADDR_W-1:0] slot_address;
	logic [ADDR_W-1:0] cur_address;
	logic              moved;

	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_mask_q <= RESET_MASK;
			rx_mask_q <= RESET_MASK;
			tx_base_q <= '0;
			rx_base_q <= '0;
		end else if (cfg_we) begin
			unique case (ndrm_cfg_idx_t'(cfg_index))
				CFG_TX_RING_LEN: tx_mask_q <= ring_mask(cfg_wdata[RLEN_W-1:0]);
				CFG_RX_RING_LEN: rx_mask_q <= ring_mask(cfg_wdata[RLEN_W-1:0]);
				CFG_TX_BUF_BASE: tx_base_q <= cfg_wdata;
				CFG_RX_BUF_BASE: rx_base_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1.cmd          <= req.cmd;
			req_s1.pkt_len      <= req.pkt_len;
			req_s1.hw_head      <= req.hw_head;
			req_s1.end_of_batch <= req.end_of_batch;
		end
	end

	// Ring arithmetic for the word in stage 1
	always_comb begin
		tx_tail_d  = tx_tail_q;
		rx_next_d  = rx_next_q;
		tx_moved_d = tx_moved_q;
		rx_moved_d = rx_moved_q;
		moved      = 1'b0;

		tail   = tx_tail_q & tx_mask_q;
		cur    = rx_next_q & rx_mask_q;
		refill = (cur - IDX_W'(1)) & rx_mask_q;
		head   = req_s1.hw_head & ((req_s1.cmd == CMD_RX) ? rx_mask_q : tx_mask_q);
		room   = (tx_mask_q - tail + head) & tx_mask_q;
		avail  = (head - cur) & rx_mask_q;

		slot         = (req_s1.cmd == CMD_RX) ? refill : tail;
		slot_base    = (req_s1.cmd == CMD_RX) ? rx_base_q : tx_base_q;
		slot_address = slot_addr(slot_base, slot);
		cur_address  = slot_addr(rx_base_q, cur);

		rsp_d.status         = ST_TX_FULL;
		rsp_d.desc_index     = '0;
		rsp_d.desc_addr      = '0;
		rsp_d.desc_word      = '0;
		rsp_d.rx_buf_addr    = '0;
		rsp_d.doorbell_valid = 1'b0;
		rsp_d.doorbell_value = '0;

		unique case (ndrm_cmd_t'(req_s1.cmd))
			CMD_TX: begin
				if (room == '0) begin
					rsp_d.status = ST_TX_FULL;
				end else if (req_s1.pkt_len > LEN_W'(BUFFER_BYTES)) begin
					// skip the packet but count it as movement
					rsp_d.status = ST_TX_OVERSIZE;
					moved        = 1'b1;
				end else begin
					rsp_d.status     = ST_TX_QUEUED;
					rsp_d.desc_index = tail;
					rsp_d.desc_addr  = slot_address;
					rsp_d.desc_word  = TXD_CMD_IFCS | TXD_CMD_EOP | WORD_W'(req_s1.pkt_len);
					tx_tail_d        = (tail + IDX_W'(1)) & tx_mask_q;
					moved            = 1'b1;
				end
				tx_moved_d = tx_moved_q | moved;
				if (req_s1.end_of_batch) begin
					rsp_d.doorbell_valid = tx_moved_d;
					rsp_d.doorbell_value = tx_moved_d ? tx_tail_d : '0;
					tx_moved_d           = 1'b0;
				end
			end
			CMD_RX: begin
				if (avail == '0) begin
					rsp_d.status = ST_RX_EMPTY;
				end else begin
					rsp_d.status      = ST_RX_DELIVERED;
					rsp_d.desc_index  = refill;
					rsp_d.desc_addr   = slot_address;
					rsp_d.desc_word   = WORD_W'(req_s1.pkt_len);
					rsp_d.rx_buf_addr = cur_address;
					rx_next_d         = (cur + IDX_W'(1)) & rx_mask_q;
					moved             = 1'b1;
				end
				rx_moved_d = rx_moved_q | moved;
				if (req_s1.end_of_batch) begin
					rsp_d.doorbell_valid = rx_moved_d;
					rsp_d.doorbell_value =
						rx_moved_d ? ((rx_next_d - IDX_W'(1)) & rx_mask_q) : '0;
					rx_moved_d           = 1'b0;
				end
			end
			default: ;
		endcase
	end

	// Pointers and batch flags advance only when the word moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_tail_q  <= '0;
			rx_next_q  <= '0;
			tx_moved_q <= 1'b0;
			rx_moved_q <= 1'b0;
		end else if (advance) begin
			tx_tail_q  <= tx_tail_d;
			rx_next_q  <= rx_next_d;
			tx_moved_q <= tx_moved_d;
			rx_moved_q <= rx_moved_d;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || rsp.ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_s2 <= rsp_d;
		end
	end

	assign rsp.valid          = valid_s2;
	assign rsp.status         = rsp_s2.status;
	assign rsp.desc_index     = rsp_s2.desc_index;
	assign rsp.desc_addr      = rsp_s2.desc_addr;
	assign rsp.desc_word      = rsp_s2.desc_word;
	assign rsp.rx_buf_addr    = rsp_s2.rx_buf_addr;
	assign rsp.doorbell_valid = rsp_s2.doorbell_valid;
	assign rsp.doorbell_value = rsp_s2.doorbell_value;

endmodule

`default_nettype wire

// ===== bench/nic_descriptor_ring_manager_core_tb.sv =====
`timescale 1ns / 1ps

module nic_descriptor_ring_manager_core_tb;
	import ndrm_pkg::*;

	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned MAX_REPORTS = 10;
	localparam logic [ADDR_W-1:0] ALL_ONES = '1;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	logic [1:0]        cfg_index;
	logic [CFG_W-1:0]  cfg_wdata;

	ndrm_req_if req_ch ();
	ndrm_rsp_if rsp_ch ();

	nic_descriptor_ring_manager_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	always #2 clk = ~clk;

	// Host side ring state as the block should hold it
	logic [RLEN_W-1:0] tx_len_reg;
	logic [RLEN_W-1:0] rx_len_reg;
	logic [ADDR_W-1:0] tx_base_reg;
	logic [ADDR_W-1:0] rx_base_reg;
	logic [IDX_W-1:0]  tx_tail_idx;
	logic [IDX_W-1:0]  rx_next_idx;
	logic              tx_batch_moved;
	logic              rx_batch_moved;

	ndrm_rsp_t   desc_result_q[$];
	int unsigned mismatch_cnt = 0;
	bit          req_idle_en  = 1'b0;
	bit          rsp_idle_en  = 1'b0;
	bit          rsp_hold_req = 1'b0;

	function automatic logic [IDX_W-1:0] slots_mask(input logic [RLEN_W-1:0] raw);
		int unsigned lim;
		int unsigned p;
		lim = 32'(raw);
		if (lim > MAX_RING_DEPTH) lim = MAX_RING_DEPTH;
		if (lim > (1 << IDX_W)) lim = 1 << IDX_W;
		if (lim < 2) lim = 2;
		p = 2;
		while (p * 2 <= lim) p = p * 2;
		return IDX_W'(p - 1);
	endfunction

	function automatic ndrm_rsp_t ring_step(input ndrm_req_t w);
		ndrm_rsp_t        r;
		logic [IDX_W-1:0] mask;
		logic [IDX_W-1:0] cur;
		logic [IDX_W-1:0] room;
		logic [IDX_W-1:0] refill;
		r = '0;
		if (w.cmd == CMD_TX) begin
			mask = slots_mask(tx_len_reg);
			cur = tx_tail_idx & mask;
			room = (mask - cur + (w.hw_head & mask)) & mask;
			if (room == '0) begin
				r.status = ST_TX_FULL;
			end else if (w.pkt_len > BUFFER_BYTES) begin
				// skipped, yet still counts as batch movement
				r.status = ST_TX_OVERSIZE;
				tx_batch_moved = 1'b1;
			end else begin
				r.status = ST_TX_QUEUED;
				r.desc_index = cur;
				r.desc_addr = tx_base_reg + ADDR_W'(cur) * ADDR_W'(BUFFER_BYTES);
				r.desc_word = TXD_CMD_IFCS | TXD_CMD_EOP | WORD_W'(w.pkt_len);
				tx_tail_idx = (cur + IDX_W'(1)) & mask;
				tx_batch_moved = 1'b1;
			end
			if (w.end_of_batch) begin
				if (tx_batch_moved) begin
					r.doorbell_valid = 1'b1;
					r.doorbell_value = tx_tail_idx;
				end
				tx_batch_moved = 1'b0;
			end
		end else begin
			mask = slots_mask(rx_len_reg);
			cur = rx_next_idx & mask;
			room = ((w.hw_head & mask) - cur) & mask;
			if (room == '0) begin
				r.status = ST_RX_EMPTY;
			end else begin
				refill = (cur - IDX_W'(1)) & mask;
				r.status = ST_RX_DELIVERED;
				r.desc_index = refill;
				r.desc_addr = rx_base_reg + ADDR_W'(refill) * ADDR_W'(BUFFER_BYTES);
				r.desc_word = WORD_W'(w.pkt_len);
				r.rx_buf_addr = rx_base_reg + ADDR_W'(cur) * ADDR_W'(BUFFER_BYTES);
				rx_next_idx = (cur + IDX_W'(1)) & mask;
				rx_batch_moved = 1'b1;
			end
			if (w.end_of_batch) begin
				if (rx_batch_moved) begin
					r.doorbell_valid = 1'b1;
					r.doorbell_value = (rx_next_idx - IDX_W'(1)) & mask;
				end
				rx_batch_moved = 1'b0;
			end
		end
		return r;
	endfunction

	// Head that leaves gap free slots in the TX ring; gap 0 means full
	function automatic logic [IDX_W-1:0] tx_head_for(input int unsigned gap, input bit hi);
		logic [IDX_W-1:0] mask;
		logic [IDX_W-1:0] h;
		mask = slots_mask(tx_len_reg);
		h = IDX_W'((tx_tail_idx & mask) + 1 + gap) & mask;
		if (hi) h = h | (IDX_W'($urandom) & ~mask);
		return h;
	endfunction

	// Head that leaves gap filled descriptors in the RX ring; gap 0 means empty
	function automatic logic [IDX_W-1:0] rx_head_for(input int unsigned gap, input bit hi);
		logic [IDX_W-1:0] mask;
		logic [IDX_W-1:0] h;
		mask = slots_mask(rx_len_reg);
		h = IDX_W'((rx_next_idx & mask) + gap) & mask;
		if (hi) h = h | (IDX_W'($urandom) & ~mask);
		return h;
	endfunction

	function automatic logic [IDX_W-1:0] pick_head(input ndrm_cmd_t c);
		int unsigned sel;
		int unsigned mask;
		sel = $urandom_range(0, 7);
		if (c == CMD_TX) begin
			mask = 32'(slots_mask(tx_len_reg));
			if (sel < 2) return tx_head_for(0, 1'($urandom_range(0, 1)));
			if (sel < 6) return tx_head_for($urandom_range(1, mask), 1'($urandom_range(0, 1)));
		end else begin
			mask = 32'(slots_mask(rx_len_reg));
			if (sel < 2) return rx_head_for(0, 1'($urandom_range(0, 1)));
			if (sel < 6) return rx_head_for($urandom_range(1, mask), 1'($urandom_range(0, 1)));
		end
		return IDX_W'($urandom);
	endfunction

	function automatic logic [LEN_W-1:0] pick_len();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return LEN_W'(BUFFER_BYTES);
			2: return LEN_W'(BUFFER_BYTES + 1);
			3: return '1;
			4, 5: return LEN_W'($urandom);
			default: return LEN_W'($urandom_range(0, BUFFER_BYTES));
		endcase
	endfunction

	task automatic send_word(input ndrm_cmd_t c, input logic [LEN_W-1:0] len,
		input logic [IDX_W-1:0] head, input logic eob);
		ndrm_req_t w;
		w.cmd = c;
		w.pkt_len = len;
		w.hw_head = head;
		w.end_of_batch = eob;
		if (req_idle_en && $urandom_range(0, 4) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.cmd <= w.cmd;
		req_ch.pkt_len <= w.pkt_len;
		req_ch.hw_head <= w.hw_head;
		req_ch.end_of_batch <= w.end_of_batch;
		do @(posedge clk); while (req_ch.ready !== 1'b1);
		desc_result_q.push_back(ring_step(w));
	endtask

	// Hold the sender until every result is back and the pipe is empty
	task automatic settle();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (desc_result_q.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input ndrm_cfg_idx_t idx, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_TX_RING_LEN: tx_len_reg = data[RLEN_W-1:0];
			CFG_RX_RING_LEN: rx_len_reg = data[RLEN_W-1:0];
			CFG_TX_BUF_BASE: tx_base_reg = data;
			CFG_RX_BUF_BASE: rx_base_reg = data;
		endcase
	endtask

	task automatic set_rings(input logic [CFG_W-1:0] tx_len, input logic [CFG_W-1:0] rx_len,
		input logic [ADDR_W-1:0] tx_base, input logic [ADDR_W-1:0] rx_base);
		settle();
		cfg_write(CFG_TX_RING_LEN, tx_len);
		cfg_write(CFG_RX_RING_LEN, rx_len);
		cfg_write(CFG_TX_BUF_BASE, tx_base);
		cfg_write(CFG_RX_BUF_BASE, rx_base);
	endtask

	// Mostly whole batches with ring-aware heads, some loose words as noise
	task automatic run_traffic(input int unsigned n_items);
		int unsigned sent;
		int unsigned blen;
		int unsigned k;
		ndrm_cmd_t   c;
		sent = 0;
		while (sent < n_items) begin
			c = ndrm_cmd_t'($urandom_range(0, 1));
			if ($urandom_range(0, 4) != 0) begin
				blen = $urandom_range(1, 8);
				for (k = 0; k < blen; k++)
					send_word(c, pick_len(), pick_head(c), k == blen - 1);
				sent += blen;
			end else begin
				send_word(c, LEN_W'($urandom), IDX_W'($urandom), 1'($urandom));
				sent++;
			end
		end
	endtask

	function automatic logic [CFG_W-1:0] small_ring();
		return CFG_W'(1) << $urandom_range(1, 4);
	endfunction

	task automatic test_after_reset();
		send_word(CMD_TX, 16'd0, 12'd0, 1'b1);
		send_word(CMD_RX, 16'd0, 12'd0, 1'b1);
		send_word(CMD_RX, 16'hffff, 12'd1, 1'b1);
	endtask

	task automatic test_tx_limits();
		set_rings(2, 2, ALL_ONES, 64'h0123_4567_89ab_cdef);
		send_word(CMD_TX, LEN_W'(BUFFER_BYTES), tx_head_for(1, 0), 1'b0);
		send_word(CMD_TX, LEN_W'(BUFFER_BYTES + 1), tx_head_for(1, 0), 1'b0);
		send_word(CMD_TX, 16'hffff, tx_head_for(0, 1), 1'b0);
		// full ring at batch end still rings for earlier movement
		send_word(CMD_TX, 16'd0, tx_head_for(0, 0), 1'b1);
		send_word(CMD_TX, 16'd5, tx_head_for(0, 0), 1'b1);
		send_word(CMD_TX, 16'd3000, tx_head_for(1, 1), 1'b1);
		send_word(CMD_TX, 16'd1, 12'hfff, 1'b1);
	endtask

	task automatic test_rx_limits();
		send_word(CMD_RX, 16'd0, rx_head_for(0, 0), 1'b1);
		send_word(CMD_RX, 16'd0, rx_head_for(1, 1), 1'b0);
		send_word(CMD_TX, 16'd100, tx_head_for(1, 0), 1'b0);
		// each batch end clears only its own direction
		send_word(CMD_RX, 16'd7, rx_head_for(0, 0), 1'b1);
		send_word(CMD_TX, 16'd9, tx_head_for(0, 0), 1'b1);
		send_word(CMD_RX, 16'hffff, 12'hfff, 1'b1);
	endtask

	task automatic test_ring_clamp();
		set_rings(ALL_ONES, 64'd1, 64'd0, 64'hffff_ffff_ffff_f800);
		send_word(CMD_TX, 16'h0800, tx_head_for(4095, 0), 1'b1);
		send_word(CMD_RX, 16'h1234, rx_head_for(1, 1), 1'b1);
		set_rings(64'hffff_ffff_ffff_e000, 64'd5000, 64'h8000_0000_0000_0000, 64'd0);
		send_word(CMD_TX, 16'h0400, 12'hfff, 1'b1);
		send_word(CMD_RX, 16'h00ff, 12'hfff, 1'b0);
		send_word(CMD_RX, 16'h8000, 12'hfff, 1'b1);
	endtask

	task automatic test_random_small_rings();
		repeat (3) begin
			set_rings(small_ring(), small_ring(), {$urandom, $urandom}, {$urandom, $urandom});
			run_traffic(84);
		end
	endtask

	task automatic test_random_full_rings();
		set_rings(4096, 4096, ALL_ONES, 64'd0);
		run_traffic(125);
		set_rings(4096, 2, 64'd0, ALL_ONES);
		run_traffic(125);
	endtask

	task automatic test_random_raw_lengths();
		repeat (3) begin
			set_rings({$urandom, $urandom}, {$urandom, $urandom},
				{$urandom, $urandom}, {$urandom, $urandom});
			run_traffic(84);
		end
	endtask

	task automatic test_backpressure();
		set_rings(8, 8, {$urandom, $urandom}, {$urandom, $urandom});
		req_idle_en = 1'b0;
		rsp_hold_req = 1'b1;
		run_traffic(40);
		req_idle_en = 1'b1;
		settle();
	endtask

	task automatic test_no_idle();
		req_idle_en = 1'b0;
		rsp_idle_en = 1'b0;
		set_rings(small_ring(), small_ring(), {$urandom, $urandom}, {$urandom, $urandom});
		run_traffic(250);
	endtask

	initial begin : rsp_ready_gen
		int unsigned stall_left;
		int unsigned hold_left;
		stall_left = 0;
		hold_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_hold_req) begin
				hold_left = HOLD_CYCLES;
				rsp_hold_req = 1'b0;
			end
			if (hold_left != 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (stall_left != 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (rsp_idle_en && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 10);
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : result_check
		ndrm_rsp_t want;
		ndrm_rsp_t got;
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			got.status = ndrm_status_t'(rsp_ch.status);
			got.desc_index = rsp_ch.desc_index;
			got.desc_addr = rsp_ch.desc_addr;
			got.desc_word = rsp_ch.desc_word;
			got.rx_buf_addr = rsp_ch.rx_buf_addr;
			got.doorbell_valid = rsp_ch.doorbell_valid;
			got.doorbell_value = rsp_ch.doorbell_value;
			if (desc_result_q.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= MAX_REPORTS)
					$display("%0t: result word with nothing pending, status %0d idx %h",
						$realtime, rsp_ch.status, rsp_ch.desc_index);
			end else begin
				want = desc_result_q.pop_front();
				if (rsp_ch.status !== want.status || got.desc_index !== want.desc_index ||
					got.desc_addr !== want.desc_addr || got.desc_word !== want.desc_word ||
					got.rx_buf_addr !== want.rx_buf_addr ||
					got.doorbell_valid !== want.doorbell_valid ||
					got.doorbell_value !== want.doorbell_value) begin
					mismatch_cnt++;
					if (mismatch_cnt <= MAX_REPORTS) begin
						$display("%0t: exp st %0d idx %h addr %h word %h rxa %h db %b/%h",
							$realtime, want.status, want.desc_index, want.desc_addr,
							want.desc_word, want.rx_buf_addr, want.doorbell_valid,
							want.doorbell_value);
						$display("%0t: got st %0d idx %h addr %h word %h rxa %h db %b/%h",
							$realtime, rsp_ch.status, got.desc_index, got.desc_addr,
							got.desc_word, got.rx_buf_addr, got.doorbell_valid,
							got.doorbell_value);
					end
				end
			end
		end
	end

	initial begin : run_limit
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin : main_seq
		tx_len_reg = 13'd256;
		rx_len_reg = 13'd256;
		tx_base_reg = '0;
		rx_base_reg = '0;
		tx_tail_idx = '0;
		rx_next_idx = '0;
		tx_batch_moved = 1'b0;
		rx_batch_moved = 1'b0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_TX_RING_LEN;
		cfg_wdata <= '0;
		req_ch.valid <= 1'b0;
		req_ch.cmd <= CMD_TX;
		req_ch.pkt_len <= '0;
		req_ch.hw_head <= '0;
		req_ch.end_of_batch <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		req_idle_en = 1'b1;
		rsp_idle_en = 1'b1;

		test_after_reset();
		test_tx_limits();
		test_rx_limits();
		test_ring_clamp();
		test_random_small_rings();
		test_random_full_rings();
		test_random_raw_lengths();
		test_backpressure();
		test_no_idle();

		settle();
		repeat (8) @(posedge clk);
		if (desc_result_q.size() != 0) begin
			$display("%0d expected result words never arrived", desc_result_q.size());
			mismatch_cnt += desc_result_q.size();
		end
		if (mismatch_cnt == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
